### rtl/wfsa_pkg.sv
package wfsa_pkg;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_FIT    = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

endpackage

### rtl/wfsa_ram.sv
module wfsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/worst_fit_segment_allocator_top.sv
// Worst-fit segment allocator with coalescing.
// The req_ channel carries one request per transaction: req_command selects
// allocate or free, req_request_size is the allocate size and req_free_address
// the start of the segment to free. The rsp_ channel returns rsp_status and
// rsp_block_address for every request, in order.
// The segment table lives in one RAM with a registered read. Each request
// but a zero-size allocate reads the table once to search (worst fit, or
// address match), then, where needed, sweeps it again to insert a split
// remainder (shifting entries up) or to merge runs of free segments
// (compacting entries down, one entry per cycle).
// After reset a clearing step writes entry 0 as one free segment spanning the
// heap; requests are taken once that step is done.
// The response is held in an output register until taken; req_ready stays low
// until then, so a stalled receiver holds off the next request.
module worst_fit_segment_allocator_top #(
   parameter int HEAP_BYTES   = 4096,
   parameter int MAX_SEGMENTS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_command,
   input  logic [12:0]             req_request_size,
   input  logic [11:0]             req_free_address,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output wfsa_pkg::status_type    rsp_status,
   output logic [11:0]             rsp_block_address
);
   import wfsa_pkg::*;

   localparam int AW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam int LW = $clog2(HEAP_BYTES + 1);
   localparam int SW = (LW > 13) ? LW : 13;
   localparam int EW = 12 + LW + 1;

   typedef struct packed {
      logic [11:0]   start;
      logic [LW-1:0] len;
      logic          used;
   } entry_type;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_SCAN, S_DECIDE, S_SPLIT_RD, S_SPLIT_WR, S_SPLIT_FIN,
      S_MERGE, S_MERGE_FIN, S_RESP
   } state_type;

   state_type        state_ff;
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    ptr_ff;       // read index
   logic [CW-1:0]    wptr_ff;      // write index
   logic             rd_vld_ff;
   logic [CW-1:0]    rd_idx_ff;
   logic             cmd_ff;
   logic [SW-1:0]    size_ff;
   logic [11:0]      where_ff;
   logic             found_ff;
   logic [AW-1:0]    best_ff;
   entry_type        best_e_ff;
   entry_type        acc_ff;       // merge accumulator
   logic             acc_vld_ff;
   logic             rsp_valid_ff;
   status_type       status_ff;
   logic [11:0]      addr_ff;

   logic             wr_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   entry_type        wr_data, rd_data;

   wfsa_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_block_address = addr_ff;

   logic [SW-1:0] rd_len_w;
   logic [SW-1:0] best_len_w;
   assign rd_len_w   = SW'(rd_data.len);
   assign best_len_w = SW'(best_e_ff.len);

   logic rd_fits;
   assign rd_fits = !rd_data.used && rd_len_w >= size_ff &&
                    (!found_ff || rd_len_w > best_len_w);

   // During the merge sweep the segment being freed counts as free.
   entry_type rd_eff;
   always_comb begin
      rd_eff      = rd_data;
      rd_eff.used = rd_data.used && (rd_idx_ff[AW-1:0] != best_ff);
   end

   // Combinational memory control; the sequencer below drives the pointers.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = wptr_ff[AW-1:0];
      wr_data = rd_data;
      rd_addr = ptr_ff[AW-1:0];
      case (state_ff)
         S_INIT: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = '{start: 12'd0, len: LW'(HEAP_BYTES), used: 1'b0};
         end
         S_SPLIT_WR: begin
            // Shift the entry read last cycle up by one.
            wr_en   = rd_vld_ff;
            wr_addr = AW'(rd_idx_ff + 1'b1);
            wr_data = rd_data;
         end
         S_SPLIT_FIN: begin
            wr_en   = 1'b1;
            wr_addr = AW'(best_ff + 1'b1);
            wr_data = '{start: best_e_ff.start + size_ff[11:0],
                        len: LW'(best_len_w - size_ff), used: 1'b0};
         end
         S_DECIDE: begin
            // Mark the chosen segment in use; split length if needed.
            wr_en   = found_ff && !cmd_ff &&
                      (best_len_w == size_ff || count_ff < CW'(MAX_SEGMENTS));
            wr_addr = best_ff;
            wr_data = '{start: best_e_ff.start, len: LW'(size_ff), used: 1'b1};
         end
         S_MERGE: begin
            wr_en   = rd_vld_ff && acc_vld_ff &&
                      !(!acc_ff.used && !rd_eff.used);
            wr_addr = wptr_ff[AW-1:0];
            wr_data = acc_ff;
         end
         S_MERGE_FIN: begin
            wr_en   = acc_vld_ff;
            wr_addr = wptr_ff[AW-1:0];
            wr_data = acc_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         count_ff     <= CW'(1);
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         ptr_ff       <= '0;
         wptr_ff      <= '0;
         acc_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_INIT: state_ff <= S_IDLE;
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff    <= req_command;
                  size_ff   <= SW'(req_request_size);
                  where_ff  <= req_free_address;
                  found_ff  <= 1'b0;
                  ptr_ff    <= '0;
                  rd_vld_ff <= 1'b0;
                  addr_ff   <= '0;
                  if (req_command == CMD_ALLOC && req_request_size == 13'd0) begin
                     status_ff    <= ST_NO_FIT;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_RESP;
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               // Issue a read per cycle; evaluate the entry read last cycle.
               rd_vld_ff <= (ptr_ff < count_ff);
               rd_idx_ff <= ptr_ff;
               if (ptr_ff < count_ff) ptr_ff <= ptr_ff + 1'b1;
               if (rd_vld_ff) begin
                  if (cmd_ff == CMD_ALLOC) begin
                     if (rd_fits) begin
                        found_ff  <= 1'b1;
                        best_ff   <= rd_idx_ff[AW-1:0];
                        best_e_ff <= rd_data;
                     end
                  end else if (!found_ff && rd_data.start == where_ff) begin
                     found_ff <= 1'b1;
                     best_ff  <= rd_idx_ff[AW-1:0];
                  end
               end
               if (!rd_vld_ff && ptr_ff >= count_ff) begin
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               if (cmd_ff == CMD_FREE) begin
                  status_ff <= found_ff ? ST_OK : ST_NOT_FOUND;
                  state_ff  <= found_ff ? S_SPLIT_RD : S_RESP;
                  rsp_valid_ff <= !found_ff;
                  // Reuse the split read state to clear the in-use mark.
                  ptr_ff    <= CW'(best_ff);
               end else if (!found_ff) begin
                  status_ff    <= ST_NO_FIT;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_RESP;
               end else if (best_len_w == size_ff) begin
                  status_ff    <= ST_OK;
                  addr_ff      <= best_e_ff.start;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_RESP;
               end else if (count_ff >= CW'(MAX_SEGMENTS)) begin
                  status_ff    <= ST_FULL;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_RESP;
               end else begin
                  status_ff <= ST_OK;
                  addr_ff   <= best_e_ff.start;
                  ptr_ff    <= count_ff - 1'b1;
                  rd_vld_ff <= 1'b0;
                  state_ff  <= S_SPLIT_RD;
               end
            end
            S_SPLIT_RD: begin
               if (cmd_ff == CMD_FREE) begin
                  // Clear mark by a merge sweep that treats best_ff as free.
                  ptr_ff     <= '0;
                  wptr_ff    <= '0;
                  rd_vld_ff  <= 1'b0;
                  acc_vld_ff <= 1'b0;
                  state_ff   <= S_MERGE;
               end else begin
                  rd_vld_ff <= (ptr_ff > CW'(best_ff));
                  rd_idx_ff <= ptr_ff;
                  state_ff  <= S_SPLIT_WR;
               end
            end
            S_SPLIT_WR: begin
               if (rd_vld_ff) begin
                  ptr_ff   <= ptr_ff - 1'b1;
                  state_ff <= S_SPLIT_RD;
               end else begin
                  state_ff <= S_SPLIT_FIN;
               end
            end
            S_SPLIT_FIN: begin
               count_ff     <= count_ff + 1'b1;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_RESP;
            end
            S_MERGE: begin
               rd_vld_ff <= (ptr_ff < count_ff);
               rd_idx_ff <= ptr_ff;
               if (ptr_ff < count_ff) ptr_ff <= ptr_ff + 1'b1;
               if (rd_vld_ff) begin
                  if (!acc_vld_ff) begin
                     acc_ff      <= rd_eff;
                     acc_vld_ff  <= 1'b1;
                  end else if (!acc_ff.used && !rd_eff.used) begin
                     acc_ff.len <= acc_ff.len + rd_data.len;
                  end else begin
                     wptr_ff     <= wptr_ff + 1'b1;
                     acc_ff      <= rd_eff;
                  end
               end
               if (!rd_vld_ff && ptr_ff >= count_ff && ptr_ff != '0) begin
                  state_ff <= S_MERGE_FIN;
               end
            end
            S_MERGE_FIN: begin
               count_ff     <= wptr_ff + 1'b1;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_RESP;
            end
            S_RESP: begin
               if (!rsp_valid_ff || rsp_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CW'(1) && count_ff <= CW'(MAX_SEGMENTS))
      else $error("segment count out of range");
   a_ready_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("request taken while a response is pending");
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> rsp_block_address == 12'd0)
      else $error("failed request returned an address");
`endif

endmodule

### bench/worst_fit_segment_allocator_top_tb.sv
`timescale 1ns / 1ps

module worst_fit_segment_allocator_top_tb;
   import wfsa_pkg::*;

   localparam int HEAP_BYTES   = 4096;
   localparam int MAX_SEGMENTS = 64;

   typedef struct packed {
      status_type  status;
      logic [11:0] address;
   } heap_reply_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic              req_command;
   logic [12:0]       req_request_size;
   logic [11:0]       req_free_address;
   logic              rsp_valid;
   logic              rsp_ready;
   status_type        rsp_status;
   logic [11:0]       rsp_block_address;

   worst_fit_segment_allocator_top #(
      .HEAP_BYTES(HEAP_BYTES),
      .MAX_SEGMENTS(MAX_SEGMENTS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_request_size(req_request_size),
      .req_free_address(req_free_address),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_block_address(rsp_block_address)
   );

   // Shadow copy of the segment table.
   logic [11:0] seg_base [MAX_SEGMENTS];
   logic [12:0] seg_len  [MAX_SEGMENTS];
   logic        seg_busy [MAX_SEGMENTS];
   int          seg_total;

   heap_reply_type expected_replies[$];
   logic [11:0] live_blocks[$];
   int          error_count = 0;
   bit          idle_allowed = 1;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   function automatic void merge_free_runs();
      int w;
      w = 0;
      for (int r = 0; r < seg_total; r++) begin
         if (w > 0 && !seg_busy[w-1] && !seg_busy[r]) begin
            seg_len[w-1] = seg_len[w-1] + seg_len[r];
         end else begin
            seg_base[w] = seg_base[r];
            seg_len[w]  = seg_len[r];
            seg_busy[w] = seg_busy[r];
            w++;
         end
      end
      seg_total = w;
   endfunction

   function automatic heap_reply_type predict_heap(input logic cmd, input logic [12:0] size,
                                                   input logic [11:0] where);
      heap_reply_type rep;
      int best;
      rep.status  = ST_OK;
      rep.address = '0;
      best = -1;
      if (cmd == CMD_FREE) begin
         rep.status = ST_NOT_FOUND;
         for (int i = 0; i < seg_total; i++) begin
            if (seg_base[i] == where) begin
               seg_busy[i] = 1'b0;
               rep.status = ST_OK;
               break;
            end
         end
         merge_free_runs();
         return rep;
      end
      if (size == 0) begin
         rep.status = ST_NO_FIT;
         return rep;
      end
      for (int i = 0; i < seg_total; i++) begin
         if (!seg_busy[i] && seg_len[i] >= size && (best < 0 || seg_len[i] > seg_len[best]))
            best = i;
      end
      if (best < 0) begin
         rep.status = ST_NO_FIT;
         return rep;
      end
      if (seg_len[best] > size) begin
         if (seg_total >= MAX_SEGMENTS) begin
            rep.status = ST_FULL;
            return rep;
         end
         for (int i = seg_total; i > best + 1; i--) begin
            seg_base[i] = seg_base[i-1];
            seg_len[i]  = seg_len[i-1];
            seg_busy[i] = seg_busy[i-1];
         end
         seg_base[best+1] = seg_base[best] + size[11:0];
         seg_len[best+1]  = seg_len[best] - size;
         seg_busy[best+1] = 1'b0;
         seg_len[best]    = size;
         seg_total++;
      end
      seg_busy[best] = 1'b1;
      rep.address = seg_base[best];
      return rep;
   endfunction

   function automatic bit take_idle();
      return idle_allowed && ($urandom_range(99) < 13);
   endfunction

   // Valid stays high after an accepted transaction until this task either
   // drives the next one or idles, so it is assigned once per edge.
   task automatic send_request(input logic cmd, input logic [12:0] size,
                               input logic [11:0] where);
      heap_reply_type rep;
      while (take_idle()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_request_size <= size;
      req_free_address <= where;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      rep = predict_heap(cmd, size, where);
      expected_replies.push_back(rep);
      if (cmd == CMD_ALLOC && rep.status == ST_OK) live_blocks.push_back(rep.address);
   endtask

   // Response side: random stalls, and every accepted transaction is checked.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_replies.size() == 0) begin
               report_mismatch("unexpected response", 1, 0);
            end else begin
               heap_reply_type want;
               want = expected_replies.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_block_address !== want.address)
                  report_mismatch("block_address", rsp_block_address, want.address);
            end
         end
         rsp_ready <= !take_idle();
      end
   end

   task automatic free_random_block();
      int k;
      logic [11:0] a;
      if (live_blocks.size() == 0) begin
         send_request(CMD_FREE, 13'($urandom), 12'($urandom));
         return;
      end
      k = $urandom_range(live_blocks.size() - 1);
      a = live_blocks[k];
      live_blocks.delete(k);
      send_request(CMD_FREE, 13'($urandom), a);
   endtask

   task automatic test_edge_cases();
      send_request(CMD_ALLOC, 13'd0, 12'hFFF);
      send_request(CMD_ALLOC, 13'd4097, 12'd0);
      send_request(CMD_ALLOC, 13'h1FFF, 12'd0);
      send_request(CMD_ALLOC, 13'd4096, 12'd0);
      send_request(CMD_ALLOC, 13'd1, 12'd0);
      send_request(CMD_FREE, 13'h1FFF, 12'd0);
      send_request(CMD_FREE, 13'd0, 12'd0);
      send_request(CMD_FREE, 13'd0, 12'd5);
      send_request(CMD_FREE, 13'd0, 12'hFFF);
      send_request(CMD_ALLOC, 13'd1, 12'd0);
      send_request(CMD_ALLOC, 13'd4095, 12'hFFF);
      send_request(CMD_FREE, 13'd0, 12'd1);
      send_request(CMD_FREE, 13'd0, 12'd0);
      live_blocks.delete();
   endtask

   // Fill the table with small blocks until splits are refused, then
   // ask for one larger block and release everything.
   task automatic test_table_full();
      for (int i = 0; i < MAX_SEGMENTS + 2; i++)
         send_request(CMD_ALLOC, 13'($urandom_range(1, 8)), 12'd0);
      send_request(CMD_ALLOC, 13'($urandom_range(9, 16)), 12'd0);
      while (live_blocks.size() > 0) free_random_block();
   endtask

   task automatic test_random_traffic(input int count);
      for (int n = 0; n < count; n++) begin
         if (n == count / 3) idle_allowed = 0;
         if (n == count / 2) idle_allowed = 1;
         case ($urandom_range(9))
            0:       send_request(CMD_ALLOC, 13'($urandom), 12'($urandom));
            1:       send_request(CMD_FREE, 13'($urandom), 12'($urandom));
            2, 3, 4: free_random_block();
            5:       send_request(CMD_ALLOC, 13'($urandom_range(1, 1024)), 12'($urandom));
            default: send_request(CMD_ALLOC, 13'($urandom_range(1, 128)), 12'($urandom));
         endcase
      end
   endtask

   initial begin
      seg_base[0] = '0;
      seg_len[0]  = 13'(HEAP_BYTES);
      seg_busy[0] = 1'b0;
      seg_total   = 1;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_command      = CMD_ALLOC;
      req_request_size = '0;
      req_free_address = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edge_cases();
      test_table_full();
      test_random_traffic(1450);
      req_valid <= 1'b0;
      while (expected_replies.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #20ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
